>>> sv/mtsx_pkg.sv
// Shared types, constants and functions for the MT19937 stream XOR block.
package mtsx_pkg;

   localparam int unsigned MT_WORDS   = 624;
   localparam int unsigned MT_SHIFT   = 397;
   localparam int unsigned POS_W      = 10;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   typedef logic [31:0]        word_type;
   typedef logic [POS_W-1:0]   pos_type;
   typedef logic [7:0]         byte_type;

   localparam word_type MT_MATRIX   = 32'h9908_b0df;
   localparam word_type MT_UPPER    = 32'h8000_0000;
   localparam word_type MT_LOWER    = 32'h7fff_ffff;
   localparam word_type MT_INIT_MUL = 32'd1812433253;
   localparam word_type TEMPER_B    = 32'h9d2c_5680;
   localparam word_type TEMPER_C    = 32'hefc6_0000;
   localparam byte_type BYTE_MASK   = 8'hff;

   localparam pos_type POS_LAST  = POS_W'(MT_WORDS - 1);
   localparam pos_type POS_WRAP  = POS_W'(MT_WORDS - MT_SHIFT);
   localparam pos_type POS_SHIFT = POS_W'(MT_SHIFT);
   localparam pos_type POS_ONE   = POS_W'(1);

   // Register index decoded from paddr[2]
   localparam logic CSR_IDX_SEED_KEY = 1'b0;

   typedef struct packed {
      logic accept;     // input transaction taken this cycle
      logic reseed;     // with accept: start seeding from the key
      logic seed_step;  // write next seed word
      logic read;       // fetch words at pos+1 and pos+397
      logic twist;      // write twisted word, load result
   } cmd_type;

   typedef struct packed {
      logic seed_last;  // current seed step writes the final word
   } status_type;

   function automatic word_type seed_next(word_type prev, pos_type idx);
      word_type x;
      x = prev ^ (prev >> 30);
      return (MT_INIT_MUL * x) + word_type'(idx);
   endfunction

   function automatic word_type twist_word(word_type cur, word_type nxt, word_type far);
      word_type y;
      y = (cur & MT_UPPER) | (nxt & MT_LOWER);
      return far ^ (y >> 1) ^ (y[0] ? MT_MATRIX : '0);
   endfunction

   function automatic word_type temper(word_type w);
      word_type v;
      v = w;
      v = v ^ (v >> 11);
      v = v ^ ((v << 7) & TEMPER_B);
      v = v ^ ((v << 15) & TEMPER_C);
      v = v ^ (v >> 18);
      return v;
   endfunction

endpackage

>>> sv/mtsx_ctrl.sv
// Control FSM: sequences accept, reseed sweep, word fetch and twist.
module mtsx_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_message_start,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mtsx_pkg::cmd_type    cmd,
   input  mtsx_pkg::status_type stat
);
   import mtsx_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEED,
      ST_READ,
      ST_TWIST
   } state_type;

   state_type state_ff;
   logic      seeded_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd           = '0;
      cmd.accept    = (state_ff == ST_IDLE) && req_valid;
      cmd.reseed    = cmd.accept && (req_message_start || !seeded_ff);
      cmd.seed_step = (state_ff == ST_SEED);
      cmd.read      = (cmd.accept && !cmd.reseed) || (state_ff == ST_READ);
      cmd.twist     = (state_ff == ST_TWIST) && (!rsp_valid_ff || !rsp_stall);
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.twist) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.reseed) begin
                  state_ff  <= ST_SEED;
                  seeded_ff <= 1'b1;
               end else if (cmd.accept) begin
                  state_ff <= ST_TWIST;
               end
            end
            ST_SEED: begin
               if (stat.seed_last) begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_TWIST;
            end
            ST_TWIST: begin
               if (cmd.twist) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

>>> sv/mtsx_dp.sv
// Datapath: generator state memory, seeding recurrence, twist and tempering.
module mtsx_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  mtsx_pkg::cmd_type    cmd,
   output mtsx_pkg::status_type stat,
   input  mtsx_pkg::word_type   seed_key,
   input  mtsx_pkg::byte_type   req_data_byte,
   output mtsx_pkg::byte_type   rsp_result_byte
);
   import mtsx_pkg::*;

   word_type mem [0:MT_WORDS-1];

   pos_type  pos_ff;
   pos_type  seed_idx_ff;
   word_type prev_ff;
   word_type cur_word_ff;
   word_type rd_next_ff;
   word_type rd_far_ff;
   byte_type data_ff;
   byte_type result_ff;

   pos_type  pos_next;
   pos_type  pos_far;
   word_type seed_word;
   word_type twisted;
   word_type key_word;

   logic     wr_en;
   pos_type  wr_addr;
   word_type wr_data;

   assign pos_next  = (pos_ff == POS_LAST) ? '0 : pos_ff + POS_ONE;
   assign pos_far   = (pos_ff >= POS_WRAP) ? pos_ff - POS_WRAP : pos_ff + POS_SHIFT;
   assign seed_word = seed_next(prev_ff, seed_idx_ff);
   assign twisted   = twist_word(cur_word_ff, rd_next_ff, rd_far_ff);
   assign key_word  = temper(twisted);

   assign stat.seed_last = (seed_idx_ff == POS_LAST);
   assign rsp_result_byte = result_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = twisted;
      priority if (cmd.reseed) begin
         wr_en   = 1'b1;
         wr_addr = '0;
         wr_data = seed_key;
      end else if (cmd.seed_step) begin
         wr_en   = 1'b1;
         wr_addr = seed_idx_ff;
         wr_data = seed_word;
      end else if (cmd.twist) begin
         wr_en   = 1'b1;
      end
   end

   // State memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.read) begin
         rd_next_ff <= mem[pos_next];
         rd_far_ff  <= mem[pos_far];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         seed_idx_ff <= POS_ONE;
      end else begin
         if (cmd.reseed) begin
            pos_ff      <= '0;
            seed_idx_ff <= POS_ONE;
         end else if (cmd.seed_step) begin
            seed_idx_ff <= seed_idx_ff + POS_ONE;
         end else if (cmd.twist) begin
            pos_ff <= pos_next;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         data_ff <= req_data_byte;
      end
      if (cmd.reseed) begin
         prev_ff     <= seed_key;
         cur_word_ff <= seed_key;
      end else if (cmd.seed_step) begin
         prev_ff <= seed_word;
      end else if (cmd.twist) begin
         cur_word_ff <= rd_next_ff;
      end
      if (cmd.twist) begin
         result_ff <= (data_ff ^ key_word[7:0]) & BYTE_MASK;
      end
   end

endmodule

>>> sv/mt19937_stream_xor.sv
// Top level: MT19937 keystream XOR cipher with APB-style key register.
//
//  channel | ports                               | direction
//  --------+-------------------------------------+----------
//  req     | req_valid/req_stall, data, start    | in
//  rsp     | rsp_valid/rsp_stall, result_byte    | out
//  csr     | psel/penable/pwrite/paddr/p*data    | in/out
//
// A transaction is an accept step (fetch of words pos+1, pos+397 on the
// two memory read ports), then a twist step (write back word pos, temper, XOR).
// A message start, or the first transaction after reset, adds a seed sweep
// (word 0 is written at accept, then one word a cycle through the single
// memory write port and the init multiplier), then a fetch step before the
// twist.
// Reset is synchronous; it clears control state and the key register.
// req_stall is high while a transaction is in work; a result held under
// rsp_stall parks the twist step, so nothing is lost.
module mt19937_stream_xor (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mtsx_pkg::byte_type                  req_data_byte,
   input  logic                                req_message_start,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mtsx_pkg::byte_type                  rsp_result_byte,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mtsx_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mtsx_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mtsx_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import mtsx_pkg::*;

   word_type   seed_key_ff;
   logic       csr_hit;
   cmd_type    cmd;
   status_type stat;

   // Register index is paddr[2]; only index 0 exists
   assign csr_hit    = (csr_paddr[2] == CSR_IDX_SEED_KEY);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? seed_key_ff : '0;

   // Key changes take effect only at the next reseed (message start or first transaction after reset)
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_key_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         seed_key_ff <= csr_pwdata;
      end
   end

   mtsx_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_message_start (req_message_start),
      .req_stall         (req_stall),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .cmd               (cmd),
      .stat              (stat)
   );

   mtsx_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .seed_key        (seed_key_ff),
      .req_data_byte   (req_data_byte),
      .rsp_result_byte (rsp_result_byte)
   );

   // Accepted transaction blocks the input until its result is produced
   a_accept_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after accepted transaction");

   // A new result only ever comes from a twist step
   a_rsp_from_twist: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.twist))
      else $error("result raised without twist");

   // Seed sweep, fetch and twist never overlap
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.seed_step, cmd.read, cmd.twist}))
      else $error("overlapping datapath commands");

   // No twist while the previous result is still held under rsp_stall
   a_twist_needs_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.twist |-> (!rsp_valid || !rsp_stall))
      else $error("twist would overwrite a pending result");

endmodule
